FILE: rtl/core/geoeb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geoeb_pkg
// Word types, threshold table, base-32 alphabet and cell divisor constants
// for the geohash error bound encoder.
// ----------------------------------------------------------------------------
package geoeb_pkg;

  localparam int LEVELS = 19;
  localparam int CHARS  = 8;

  typedef struct packed {
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic        [31:0] tolerance;
  } geo_in_t;

  typedef struct packed {
    logic [6:0] code_char0;
    logic [6:0] code_char1;
    logic [6:0] code_char2;
    logic [6:0] code_char3;
    logic [6:0] code_char4;
    logic [6:0] code_char5;
    logic [6:0] code_char6;
    logic [6:0] code_char7;
    logic [4:0] level_count;
    logic       out_of_range;
  } geo_out_t;

  // Error thresholds in 1e-9 degree, decreasing.
  localparam logic [31:0] TOL_THRESH [LEVELS] = '{
    32'd540000000, 32'd270000000, 32'd130000000, 32'd68000000, 32'd34000000,
    32'd17000000,  32'd8500000,   32'd4200000,   32'd2100000,  32'd1000000,
    32'd530000,    32'd260000,    32'd130000,    32'd65000,    32'd32000,
    32'd16000,     32'd8300,      32'd4100,      32'd2000
  };

  localparam logic signed [31:0] LON_HALF = 32'sd1800000000;
  localparam logic signed [31:0] LAT_HALF = 32'sd900000000;

  // Offset coordinate u (0..3.6e9) maps to cell index floor(u * 2^9 / CELL_DIV).
  localparam logic [21:0] CELL_DIV    = 22'd3515625;
  localparam logic [31:0] RECIP       = 32'd2562047788;
  localparam int          RECIP_SHIFT = 44;

  localparam logic [6:0] CHAR_BANG = 7'd33;

  localparam logic [255:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

  function automatic logic [6:0] geo_char(input logic [4:0] idx);
    logic [7:0] c;
    c = ALPHABET[255 - 8 * int'(idx) -: 8];
    return c[6:0];
  endfunction

endpackage

FILE: rtl/core/geohash_error_bound_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geohash_error_bound_encoder
// Encodes a point and error tolerance as a geohash of up to eight characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel point_valid / point_ready carries one geo_in_t word
//   (longitude and latitude in 1e-7 degree, tolerance in 1e-9 degree).
//   Output channel code_valid / code_ready carries one geo_out_t word per
//   input word, in order.
//   From acceptance a word passes through the input register, offset and
//   depth, reciprocal multiply, remainder multiply, correction and
//   character encode into the result register. Throughput is one word
//   per cycle while code_ready is high; each stage is a plain register stage.
//   When the receiver holds code_ready low the result word holds and the
//   stages behind it fill up; point_ready drops only once every stage holds
//   a word. Each stage moves on as soon as the stage after it is free.
//   Reset empties all stages; no word is lost across a stall.
// ----------------------------------------------------------------------------
module geohash_error_bound_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_ready,
  input  geoeb_pkg::geo_in_t point,
  output logic               code_valid,
  input  logic               code_ready,
  output geoeb_pkg::geo_out_t code
);

  // Stage valid bits
  logic a_valid, b_valid, c_valid, d_valid;
  logic a_take, b_take, c_take, d_take, o_take;

  // Stage A: input register
  geoeb_pkg::geo_in_t a_word;

  // Stage B: offset coordinates and depth
  logic [31:0] b_ulon, b_ulat;
  logic [4:0]  b_depth;
  logic        b_oor;

  // Stage C: estimated cell index
  logic [31:0] c_ulon, c_ulat;
  logic [19:0] c_qlon, c_qlat;
  logic [4:0]  c_depth;
  logic        c_oor;

  // Stage D: back product for correction
  logic [31:0] d_ulon, d_ulat;
  logic [19:0] d_qlon, d_qlat;
  logic [41:0] d_tlon, d_tlat;
  logic [4:0]  d_depth;
  logic        d_oor;

  // Combinational values
  logic signed [32:0] lon_off, lat_off;
  logic [31:0]        ulon_next, ulat_next;
  logic               oor_next;
  logic [4:0]         depth_next;
  logic [63:0]        plon, plat;
  logic [41:0]        rlon, rlat;
  logic [19:0]        qlon_fix, qlat_fix;
  logic [18:0]        qlon, qlat;
  logic [37:0]        bits, mask;
  logic [39:0]        padded;
  logic [5:0]         nbits;
  logic [6:0]         chars [geoeb_pkg::CHARS];
  geoeb_pkg::geo_out_t code_next;

  assign o_take      = !code_valid || code_ready;
  assign d_take      = !d_valid || o_take;
  assign c_take      = !c_valid || d_take;
  assign b_take      = !b_valid || c_take;
  assign a_take      = !a_valid || b_take;
  assign point_ready = a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      d_valid    <= 1'b0;
      code_valid <= 1'b0;
    end else begin
      if (a_take) a_valid <= point_valid;
      if (b_take) b_valid <= a_valid;
      if (c_take) c_valid <= b_valid;
      if (d_take) d_valid <= c_valid;
      if (o_take) code_valid <= d_valid;
    end
  end

  // Stage A -> B: range check, offset, depth
  always_comb begin
    lon_off   = 33'(a_word.longitude) + 33'(geoeb_pkg::LON_HALF);
    lat_off   = 33'(a_word.latitude) + 33'(geoeb_pkg::LAT_HALF);
    ulon_next = lon_off[31:0];
    ulat_next = {lat_off[30:0], 1'b0};
    oor_next  = (a_word.longitude < -geoeb_pkg::LON_HALF) ||
                (a_word.longitude > geoeb_pkg::LON_HALF) ||
                (a_word.latitude < -geoeb_pkg::LAT_HALF) ||
                (a_word.latitude > geoeb_pkg::LAT_HALF);
    depth_next = 5'd0;
    for (int i = 0; i < geoeb_pkg::LEVELS; i++) begin
      if (a_word.tolerance <= geoeb_pkg::TOL_THRESH[i]) depth_next = 5'(i + 1);
    end
    if (oor_next) depth_next = 5'd0;
  end

  // Stage B -> C: reciprocal multiply
  assign plon = 64'(b_ulon) * 64'(geoeb_pkg::RECIP);
  assign plat = 64'(b_ulat) * 64'(geoeb_pkg::RECIP);

  // Stage D -> out: remainder correction, interleave, encode
  always_comb begin
    rlon     = {1'b0, d_ulon, 9'd0} - d_tlon;
    rlat     = {1'b0, d_ulat, 9'd0} - d_tlat;
    qlon_fix = d_qlon + 20'(rlon >= 42'(geoeb_pkg::CELL_DIV));
    qlat_fix = d_qlat + 20'(rlat >= 42'(geoeb_pkg::CELL_DIV));
    qlon     = qlon_fix[19] ? 19'h7ffff : qlon_fix[18:0];
    qlat     = qlat_fix[19] ? 19'h7ffff : qlat_fix[18:0];
    for (int j = 0; j < geoeb_pkg::LEVELS; j++) begin
      bits[37 - 2 * j] = qlon[18 - j];
      bits[36 - 2 * j] = qlat[18 - j];
    end
    nbits = {d_depth, 1'b0};
    for (int p = 0; p < 38; p++) begin
      mask[37 - p] = (6'(p) < nbits);
    end
    padded = {bits & mask, 2'b00};
    for (int k = 0; k < geoeb_pkg::CHARS; k++) begin
      chars[k] = (6'(5 * k) < nbits) ? geoeb_pkg::geo_char(padded[39 - 5 * k -: 5]) : 7'd0;
    end
    code_next.code_char0   = d_oor ? geoeb_pkg::CHAR_BANG : chars[0];
    code_next.code_char1   = chars[1];
    code_next.code_char2   = chars[2];
    code_next.code_char3   = chars[3];
    code_next.code_char4   = chars[4];
    code_next.code_char5   = chars[5];
    code_next.code_char6   = chars[6];
    code_next.code_char7   = chars[7];
    code_next.level_count  = d_depth;
    code_next.out_of_range = d_oor;
  end

  always_ff @(posedge clk) begin
    if (a_take) a_word <= point;
    if (b_take) begin
      b_ulon  <= ulon_next;
      b_ulat  <= ulat_next;
      b_depth <= depth_next;
      b_oor   <= oor_next;
    end
    if (c_take) begin
      c_ulon  <= b_ulon;
      c_ulat  <= b_ulat;
      c_qlon  <= plon[geoeb_pkg::RECIP_SHIFT +: 20];
      c_qlat  <= plat[geoeb_pkg::RECIP_SHIFT +: 20];
      c_depth <= b_depth;
      c_oor   <= b_oor;
    end
    if (d_take) begin
      d_ulon  <= c_ulon;
      d_ulat  <= c_ulat;
      d_qlon  <= c_qlon;
      d_qlat  <= c_qlat;
      d_tlon  <= 42'(c_qlon) * 42'(geoeb_pkg::CELL_DIV);
      d_tlat  <= 42'(c_qlat) * 42'(geoeb_pkg::CELL_DIV);
      d_depth <= c_depth;
      d_oor   <= c_oor;
    end
    if (o_take) code <= code_next;
  end

endmodule

FILE: rtl/core/geoeb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geoeb_checker
// Port-level checks for the geohash error bound encoder, bound to the top.
// ----------------------------------------------------------------------------
module geoeb_checker (
  input logic                clk,
  input logic                rst,
  input logic                point_valid,
  input logic                point_ready,
  input logic                code_valid,
  input logic                code_ready,
  input geoeb_pkg::geo_out_t code
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(code))
    else $error("result word changed while stalled");

  a_oor_word: assert property (@(posedge clk) disable iff (rst)
    code_valid && code.out_of_range |->
      code.code_char0 == geoeb_pkg::CHAR_BANG && code.code_char1 == 7'd0 &&
      code.level_count == 5'd0)
    else $error("out of range word malformed");

  a_depth_chars: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code.out_of_range && code.level_count == 5'd0 |->
      code.code_char0 == 7'd0 && code.code_char7 == 7'd0)
    else $error("characters present at depth zero");

  a_level_max: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> code.level_count <= 5'(geoeb_pkg::LEVELS))
    else $error("level count above table size");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_ready && code_ready) ##1 code_ready ##1 code_ready
      ##1 code_ready ##1 code_ready |=> code_valid)
    else $error("result missing after pipeline latency");

endmodule

bind geohash_error_bound_encoder geoeb_checker u_geoeb_checker (
  .clk         (clk),
  .rst         (rst),
  .point_valid (point_valid),
  .point_ready (point_ready),
  .code_valid  (code_valid),
  .code_ready  (code_ready),
  .code        (code)
);
